// ----- rtl/yuyv_pkg.sv -----
// Shared types, constants and helper functions for the YUYV to BGRA red-threshold converter.
// Has no dependencies; every other file in rtl/ imports it.
package yuyv_pkg;

	localparam int unsigned AddrWidth = 3;
	localparam int unsigned DataWidth = 32;

	localparam logic [7:0] ThresholdReset = 8'd64;
	localparam logic signed [8:0] ChromaOffset = 9'sd128;
	localparam logic signed [17:0] CoefGu = -18'sd100;
	localparam logic signed [17:0] CoefGv = -18'sd208;
	localparam logic signed [17:0] CoefRv = 18'sd409;
	localparam logic [7:0] ChanMax = 8'd255;
	localparam logic [7:0] MarkOn = 8'd255;
	localparam logic [7:0] MarkOff = 8'd0;

	localparam logic RegThreshold = 1'b0;

	typedef struct packed {
		logic signed [9:0] bd;
		logic signed [9:0] gd;
		logic signed [9:0] rd;
	} chroma_delta_t;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red_mark;
	} pixel_t;

	function automatic logic [7:0] clamp8(input logic signed [10:0] x);
		logic [7:0] r;
		if (x[10]) begin
			r = 8'd0;
		end else if (x[9:8] != 2'b00) begin
			r = ChanMax;
		end else begin
			r = x[7:0];
		end
		return r;
	endfunction

endpackage

// ----- rtl/yuyv_to_bgra_red_threshold.sv -----
// Top level of the YUYV 4:2:2 to blue/green/red-mark converter.
// Depends on yuyv_pkg, yuyv_cfg, yuyv_chroma and yuyv_pixel.
//
// Usage: a macropixel (luma_first, chroma_blue, luma_second, chroma_red) is
// taken as a transaction at a rising edge where start is high and busy is low.
// Busy is always low, so one macropixel can be taken every clock cycle.
// The macropixel is captured in an input register, converted by one pass of
// combinational logic, and caught in a result register. After both registers,
// the result transaction appears: done is high for exactly one cycle with
// both converted pixels on the result ports. Throughput is one macropixel per
// cycle, set by the single register-to-register conversion path.
// The receiver cannot stall; it must take each result in the cycle done is high.
// The red threshold is written through the APB port at byte address 0 and must
// only change while no transaction is in flight.
// Reset clears the pipeline valid flags and sets the threshold to 64; no
// result is produced until a new transaction is accepted.
module yuyv_to_bgra_red_threshold (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [yuyv_pkg::AddrWidth-1:0]   paddr,
	input  logic [yuyv_pkg::DataWidth-1:0]   pwdata,
	output logic [yuyv_pkg::DataWidth-1:0]   prdata,
	output logic                             pready,
	input  logic                             start,
	output logic                             busy,
	input  logic [7:0]                       luma_first,
	input  logic [7:0]                       chroma_blue,
	input  logic [7:0]                       luma_second,
	input  logic [7:0]                       chroma_red,
	output logic                             done,
	output logic [7:0]                       blue_first,
	output logic [7:0]                       green_first,
	output logic [7:0]                       red_mark_first,
	output logic [7:0]                       blue_second,
	output logic [7:0]                       green_second,
	output logic [7:0]                       red_mark_second
);
	import yuyv_pkg::*;

	logic          accept;
	logic          valid_s1;
	logic          valid_s2;
	logic [7:0]    luma_first_s1;
	logic [7:0]    luma_second_s1;
	logic [7:0]    chroma_blue_s1;
	logic [7:0]    chroma_red_s1;
	logic [7:0]    red_threshold;
	chroma_delta_t delta;
	pixel_t        pix_first;
	pixel_t        pix_second;
	pixel_t        pix_first_s2;
	pixel_t        pix_second_s2;

	assign busy = 1'b0;
	assign accept = start && !busy;

	yuyv_cfg u_cfg (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.red_threshold (red_threshold)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			luma_first_s1 <= luma_first;
			luma_second_s1 <= luma_second;
			chroma_blue_s1 <= chroma_blue;
			chroma_red_s1 <= chroma_red;
		end
	end

	yuyv_chroma u_chroma (
		.chroma_blue (chroma_blue_s1),
		.chroma_red  (chroma_red_s1),
		.delta       (delta)
	);

	yuyv_pixel u_pixel_first (
		.luma          (luma_first_s1),
		.delta         (delta),
		.red_threshold (red_threshold),
		.pixel         (pix_first)
	);

	yuyv_pixel u_pixel_second (
		.luma          (luma_second_s1),
		.delta         (delta),
		.red_threshold (red_threshold),
		.pixel         (pix_second)
	);

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			pix_first_s2 <= pix_first;
			pix_second_s2 <= pix_second;
		end
	end

	assign done = valid_s2;
	assign blue_first = pix_first_s2.blue;
	assign green_first = pix_first_s2.green;
	assign red_mark_first = pix_first_s2.red_mark;
	assign blue_second = pix_second_s2.blue;
	assign green_second = pix_second_s2.green;
	assign red_mark_second = pix_second_s2.red_mark;

	a_done_follows_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ##1 done)
		else $error("result transaction missing two cycles after acceptance");

	a_done_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(valid_s1))
		else $error("result strobe without a converted transaction");

	a_mark_levels: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((red_mark_first == MarkOn || red_mark_first == MarkOff) &&
			(red_mark_second == MarkOn || red_mark_second == MarkOff)))
		else $error("red mark is neither fully on nor off");

	a_top_threshold: assert property (@(posedge clk) disable iff (!arst_n)
		(done && red_threshold == ChanMax) |->
			(red_mark_first == MarkOff && red_mark_second == MarkOff))
		else $error("red mark set with threshold at full scale");

endmodule

// ----- rtl/yuyv_cfg.sv -----
// Configuration register file with an APB-style slave port.
// Depends on yuyv_pkg for the address width and the threshold reset value.
module yuyv_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [yuyv_pkg::AddrWidth-1:0]   paddr,
	input  logic [yuyv_pkg::DataWidth-1:0]   pwdata,
	output logic [yuyv_pkg::DataWidth-1:0]   prdata,
	output logic                             pready,
	output logic [7:0]                       red_threshold
);
	import yuyv_pkg::*;

	logic [7:0] threshold_q;
	logic       hit;

	assign hit = (paddr[2] == RegThreshold);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= ThresholdReset;
		end else if (psel && penable && pwrite && hit) begin
			threshold_q <= pwdata[7:0];
		end
	end

	always_comb begin
		if (hit) begin
			prdata = {{(DataWidth-8){1'b0}}, threshold_q};
		end else begin
			prdata = '0;
		end
	end

	assign red_threshold = threshold_q;

endmodule

// ----- rtl/yuyv_chroma.sv -----
// Chroma term generator: turns the shared U and V samples into the blue, green and red offsets.
// Depends on yuyv_pkg for the coefficients and the offset struct.
module yuyv_chroma (
	input  logic [7:0]                    chroma_blue,
	input  logic [7:0]                    chroma_red,
	output yuyv_pkg::chroma_delta_t       delta
);
	import yuyv_pkg::*;

	logic signed [8:0]  u;
	logic signed [8:0]  v;
	logic signed [17:0] g_sum;
	logic signed [17:0] r_prod;

	always_comb begin
		u = $signed({1'b0, chroma_blue}) - ChromaOffset;
		v = $signed({1'b0, chroma_red}) - ChromaOffset;
		g_sum = CoefGu * 18'(u) + CoefGv * 18'(v);
		r_prod = CoefRv * 18'(v);
		delta.bd = $signed({u, 1'b0});
		delta.gd = g_sum[17:8];
		delta.rd = r_prod[17:8];
	end

endmodule

// ----- rtl/yuyv_pixel.sv -----
// Per-pixel channel logic: adds the chroma offsets to one luma, clamps and marks red.
// Depends on yuyv_pkg for the offset and pixel structs and the clamp function.
module yuyv_pixel (
	input  logic [7:0]                 luma,
	input  yuyv_pkg::chroma_delta_t    delta,
	input  logic [7:0]                 red_threshold,
	output yuyv_pkg::pixel_t           pixel
);
	import yuyv_pkg::*;

	logic signed [10:0] b_sum;
	logic signed [10:0] g_sum;
	logic signed [10:0] r_sum;
	logic [7:0]         red;

	always_comb begin
		b_sum = $signed({3'b000, luma}) + 11'(delta.bd);
		g_sum = $signed({3'b000, luma}) + 11'(delta.gd);
		r_sum = $signed({3'b000, luma}) + 11'(delta.rd);
		red = clamp8(r_sum);
		pixel.blue = clamp8(b_sum);
		pixel.green = clamp8(g_sum);
		pixel.red_mark = (red > red_threshold) ? MarkOn : MarkOff;
	end

endmodule
